FILE: rtl/pbb_pkg.sv
package pbb_pkg;

  localparam int MAX_PARTICLES = 16384;
  localparam int COUNT_MAX     = 32767;
  localparam int COUNT_CAP     = (MAX_PARTICLES < COUNT_MAX) ? MAX_PARTICLES : COUNT_MAX;
  localparam int COUNT_W       = 15;
  localparam int SUM_W         = 48;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic signed [33:0] WALL_RIGHT = 34'sd68812800;  // 1050.0
  localparam logic signed [33:0] WALL_LEFT  = 34'sd22937600;  // 350.0
  localparam logic signed [33:0] WALL_TOP   = 34'sd45875200;  // 700.0

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  localparam logic [30:0]        TIME_STEP_RESET = 31'd65536;
  localparam logic signed [31:0] GRAVITY_RESET   = -32'sd642;
  localparam logic [30:0]        RADIUS_RESET    = 31'd131072;

  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_GRAVITY   = 2'd1;
  localparam logic [1:0] REG_RADIUS    = 2'd2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [31:0] right;
    logic signed [32:0] left_cmp;
    logic signed [31:0] left_clamp;
    logic signed [31:0] top;
    logic signed [31:0] bottom;
  } wall_lim_t;

  typedef struct packed {
    logic signed [31:0]   pos_x;
    logic signed [31:0]   pos_y;
    logic signed [31:0]   vel_x;
    logic signed [31:0]   vel_y;
    logic [30:0]          speed;
    logic                 last;
    logic [SUM_W-1:0]     sum;
    logic [COUNT_W-1:0]   count;
  } item_t;

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == S32_MIN) r = S32_MAX;
    else r = -v;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7fff_ffff) r = S32_MAX;
    else if (v < -48'sh0000_8000_0000) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic wall_lim_t calc_limits(input logic [30:0] radius);
    wall_lim_t        l;
    logic signed [33:0] r;
    logic signed [33:0] left;
    logic signed [33:0] right;
    logic signed [33:0] top;
    r     = $signed({3'b000, radius});
    right = WALL_RIGHT - r;
    left  = WALL_LEFT + r;
    top   = WALL_TOP - r;
    l.right    = right[31:0];
    l.left_cmp = left[32:0];
    if (left > 34'sh0_7fff_ffff) l.left_clamp = S32_MAX;
    else l.left_clamp = left[31:0];
    l.top    = top[31:0];
    l.bottom = $signed({1'b0, radius});
    return l;
  endfunction

endpackage

FILE: rtl/pbb_front.sv
module pbb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata fields from bit 0: pos_x, pos_y, vel_x, vel_y, speed, one pad bit
  input  logic [159:0]      s_axis_tdata,
  input  logic              s_axis_tlast,
  input  pbb_pkg::wall_lim_t lim_i,
  input  logic              q_ready_i,
  output logic              push_o,
  output pbb_pkg::item_t    item_o
);
  import pbb_pkg::*;

  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [COUNT_W-1:0] count_q, count_d;

  logic signed [31:0] x0, y0, vx0, vy0;
  logic signed [31:0] x1, vx1, x2, vx2;
  logic signed [31:0] y1, vy1, y2, vy2;
  logic [30:0]        spd;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_new;
  logic [COUNT_W-1:0] count_new;

  assign x0  = $signed(s_axis_tdata[31:0]);
  assign y0  = $signed(s_axis_tdata[63:32]);
  assign vx0 = $signed(s_axis_tdata[95:64]);
  assign vy0 = $signed(s_axis_tdata[127:96]);
  assign spd = s_axis_tdata[158:128];

  // Each wall check works on the outcome of the one before it, so with
  // overlapping walls the left and bottom checks have the last word.
  always_comb begin
    x1  = x0;
    vx1 = vx0;
    if (x0 > lim_i.right) begin
      x1  = lim_i.right;
      vx1 = neg_sat(vx0);
    end
    x2  = x1;
    vx2 = vx1;
    if ($signed({x1[31], x1}) < lim_i.left_cmp) begin
      x2  = lim_i.left_clamp;
      vx2 = neg_sat(vx1);
    end
    y1  = y0;
    vy1 = vy0;
    if (y0 > lim_i.top) begin
      y1  = lim_i.top;
      vy1 = neg_sat(vy0);
    end
    y2  = y1;
    vy2 = vy1;
    if (y1 < lim_i.bottom) begin
      y2  = lim_i.bottom;
      vy2 = neg_sat(vy1);
    end
  end

  always_comb begin
    sum_add   = {1'b0, sum_q} + {{(SUM_W - 30){1'b0}}, spd};
    sum_new   = sum_q;
    count_new = count_q;
    if (count_q < COUNT_W'(COUNT_CAP)) begin
      sum_new   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      count_new = count_q + 1'b1;
    end
  end

  assign s_axis_tready = q_ready_i;
  assign push_o        = s_axis_tvalid && q_ready_i;

  always_comb begin
    item_o.pos_x = x2;
    item_o.pos_y = y2;
    item_o.vel_x = vx2;
    item_o.vel_y = vy2;
    item_o.speed = spd;
    item_o.last  = s_axis_tlast;
    item_o.sum   = sum_new;
    item_o.count = count_new;
  end

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    if (push_o) begin
      if (s_axis_tlast) begin
        sum_d   = '0;
        count_d = '0;
      end else begin
        sum_d   = sum_new;
        count_d = count_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

endmodule

FILE: rtl/pbb_queue.sv
module pbb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pbb_pkg::item_t data_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pbb_pkg::item_t data_o
);
  import pbb_pkg::*;

  item_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QUEUE_AW:0]   fill_q, fill_d;
  logic                do_pop;

  assign ready_o = (fill_q != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign valid_o = (fill_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) wr_d = (wr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop) rd_d = (rd_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (push_i && !do_pop) fill_d = fill_q + 1'b1;
    else if (!push_i && do_pop) fill_d = fill_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

endmodule

FILE: rtl/pbb_back.sv
module pbb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [30:0]        time_step_i,
  input  logic signed [31:0] gravity_i,
  input  logic               q_valid_i,
  input  pbb_pkg::item_t     q_data_i,
  output logic               pop_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // tdata fields from bit 0: new_pos_x, new_pos_y, new_vel_x, new_vel_y,
  // speed_out, mean_speed, two pad bits
  output logic [191:0]       m_axis_tdata,
  output logic               m_axis_tlast
);
  import pbb_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_ADD1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_ADD2 = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  localparam int DIV_CW = $clog2(SUM_W);

  logic [2:0]         state_q, state_d;
  logic signed [31:0] x_q, x_d, y_q, y_d, vx_q, vx_d, vy_q, vy_d;
  logic [30:0]        spd_q, spd_d;
  logic               last_q, last_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic signed [63:0] pa_q, pa_d, pb_q, pb_d;
  logic [SUM_W-1:0]   dv_q, dv_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [DIV_CW-1:0]  step_q, step_d;

  logic signed [31:0] ts_s;
  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W+1:0] trial;

  assign ts_s = $signed({1'b0, time_step_i});

  // One restoring division step: shift in the next dividend bit, subtract
  // the divisor if it fits, and feed the quotient bit into the low end.
  assign rem_sh = {rem_q, dv_q[SUM_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, cnt_q};

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    vx_d    = vx_q;
    vy_d    = vy_q;
    spd_d   = spd_q;
    last_d  = last_q;
    cnt_d   = cnt_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    dv_d    = dv_q;
    rem_d   = rem_q;
    step_d  = step_q;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          x_d     = q_data_i.pos_x;
          y_d     = q_data_i.pos_y;
          vx_d    = q_data_i.vel_x;
          vy_d    = q_data_i.vel_y;
          spd_d   = q_data_i.speed;
          last_d  = q_data_i.last;
          cnt_d   = q_data_i.count;
          dv_d    = q_data_i.sum;
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        pa_d    = gravity_i * ts_s;
        pb_d    = vx_q * ts_s;
        state_d = ST_ADD1;
      end
      ST_ADD1: begin
        // Taking the upper bits of a signed product floors the shifted value.
        vy_d    = sat32({{16{vy_q[31]}}, vy_q} + pa_q[63:16]);
        x_d     = sat32({{16{x_q[31]}}, x_q} + pb_q[63:16]);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        pa_d    = vy_q * ts_s;
        state_d = ST_ADD2;
      end
      ST_ADD2: begin
        y_d    = sat32({{16{y_q[31]}}, y_q} + pa_q[63:16]);
        rem_d  = '0;
        step_d = '0;
        if (last_q && (cnt_q != '0)) begin
          state_d = ST_DIV;
        end else begin
          dv_d    = '0;
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (!trial[COUNT_W+1]) begin
          rem_d = trial[COUNT_W-1:0];
          dv_d  = {dv_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[COUNT_W-1:0];
          dv_d  = {dv_q[SUM_W-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == DIV_CW'(SUM_W - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {2'b00, dv_q[30:0], spd_q, vy_q, vx_q, y_q, x_q};

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    spd_q  <= spd_d;
    cnt_q  <= cnt_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    dv_q   <= dv_d;
    rem_q  <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: rtl/particle_box_bounce_step_top.sv
// A particle passes the front wall checks, the queue and the back end's sequence;
// the last particle of a frame also goes through the bit-serial mean-speed division.
// Throughput: set by the back end's multiply-add sequence, which waits for each result
// to be taken; a two-entry queue lets the front take particles while a result waits.
// Reset: asynchronous, active low; clears the frame sum and count, the queue and
// sequencer, and restores time step 1.0, gravity -0.0098 and radius 2.0.
module particle_box_bounce_step_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata fields from bit 0: pos_x, pos_y, vel_x, vel_y, speed, one pad bit
  input  logic [159:0]  s_axis_tdata,
  input  logic          s_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata fields from bit 0: new_pos_x, new_pos_y, new_vel_x, new_vel_y,
  // speed_out, mean_speed, two pad bits
  output logic [191:0]  m_axis_tdata,
  output logic          m_axis_tlast
);
  import pbb_pkg::*;

  logic [30:0]        ts_q;
  logic signed [31:0] grav_q;
  wall_lim_t          lim_q;

  logic  push, q_ready, q_valid, pop;
  item_t front_item, q_item;

  // The wall limits are worked out when the radius is written, keeping the
  // adders out of the compare path.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q   <= TIME_STEP_RESET;
      grav_q <= GRAVITY_RESET;
      lim_q  <= calc_limits(RADIUS_RESET);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TIME_STEP: ts_q   <= cfg_data_i[30:0];
        REG_GRAVITY:   grav_q <= $signed(cfg_data_i);
        REG_RADIUS:    lim_q  <= calc_limits(cfg_data_i[30:0]);
        default: ;
      endcase
    end
  end

  pbb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .lim_i         (lim_q),
    .q_ready_i     (q_ready),
    .push_o        (push),
    .item_o        (front_item)
  );

  pbb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  pbb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .time_step_i   (ts_q),
    .gravity_i     (grav_q),
    .q_valid_i     (q_valid),
    .q_data_i      (q_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: bench/pbb_checker.sv
module pbb_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  // fields from bit 0: pos_x, pos_y, vel_x, vel_y, speed, one pad bit
  input  logic [159:0] s_tdata_i,
  input  logic         s_tlast_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  // fields from bit 0: new_pos_x, new_pos_y, new_vel_x, new_vel_y, speed_out,
  // mean_speed, two pad bits
  input  logic [191:0] m_tdata_i,
  input  logic         m_tlast_i,
  output int           pending_o,
  output int           failures_o
);
  import pbb_pkg::*;

  localparam longint RIGHT_WALL = 64'sd68812800;
  localparam longint LEFT_WALL  = 64'sd22937600;
  localparam longint TOP_WALL   = 64'sd45875200;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [30:0]        speed;
    logic [30:0]        mean;
    logic               done;
  } motion_t;

  logic [30:0]        step_q;
  logic signed [31:0] gravity_q;
  logic [30:0]        radius_q;
  logic [47:0]        speed_total;
  logic [14:0]        particle_tally;
  motion_t            predicted_moves[$];
  int                 mismatches = 0;
  string              field_name[7] = '{"new_pos_x", "new_pos_y", "new_vel_x", "new_vel_y",
                                        "speed_out", "mean_speed", "frame_done"};

  assign failures_o = mismatches;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Arithmetic shift of a signed product rounds toward minus infinity.
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic motion_t move_particle(input logic [159:0] d, input logic last);
    longint      x;
    longint      y;
    longint      vx;
    longint      vy;
    longint      r;
    longint      ts;
    logic [48:0] grown;
    logic [47:0] quotient;
    motion_t     m;
    x  = longint'($signed(d[31:0]));
    y  = longint'($signed(d[63:32]));
    vx = longint'($signed(d[95:64]));
    vy = longint'($signed(d[127:96]));
    r  = longint'(radius_q);
    ts = longint'(step_q);

    // Walls in order right, left, top, bottom; each sees the previous outcome.
    if (x > RIGHT_WALL - r) begin
      x  = clip32(RIGHT_WALL - r);
      vx = clip32(-vx);
    end
    if (x < LEFT_WALL + r) begin
      x  = clip32(LEFT_WALL + r);
      vx = clip32(-vx);
    end
    if (y > TOP_WALL - r) begin
      y  = clip32(TOP_WALL - r);
      vy = clip32(-vy);
    end
    if (y < r) begin
      y  = clip32(r);
      vy = clip32(-vy);
    end

    vy = clip32(vy + fx_mul(longint'(gravity_q), ts));
    x  = clip32(x + fx_mul(vx, ts));
    y  = clip32(y + fx_mul(vy, ts));

    m.pos_x = x[31:0];
    m.pos_y = y[31:0];
    m.vel_x = vx[31:0];
    m.vel_y = vy[31:0];
    m.speed = d[158:128];
    m.done  = last;
    m.mean  = '0;

    if (particle_tally < COUNT_CAP) begin
      grown = {1'b0, speed_total} + d[158:128];
      speed_total = grown[48] ? SUM_MAX : grown[47:0];
      particle_tally++;
    end
    if (last) begin
      quotient = (particle_tally != 0) ? speed_total / particle_tally : '0;
      m.mean = quotient[30:0];
      speed_total = '0;
      particle_tally = '0;
    end
    return m;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    motion_t e;
    longint  want[7];
    longint  seen[7];
    if (!rst_ni) begin
      step_q         = TIME_STEP_RESET;
      gravity_q      = GRAVITY_RESET;
      radius_q       = RADIUS_RESET;
      speed_total    = '0;
      particle_tally = '0;
      predicted_moves.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TIME_STEP: step_q = cfg_data_i[30:0];
          REG_GRAVITY:   gravity_q = $signed(cfg_data_i);
          REG_RADIUS:    radius_q = cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        predicted_moves = {predicted_moves, move_particle(s_tdata_i, s_tlast_i)};
      if (m_tvalid_i && m_tready_i) begin
        if (predicted_moves.size() == 0) begin
          $error("result transaction with no particle outstanding");
          mismatches++;
        end else begin
          e = predicted_moves.pop_front();
          want = '{e.pos_x, e.pos_y, e.vel_x, e.vel_y, e.speed, e.mean, e.done};
          seen = '{$signed(m_tdata_i[31:0]), $signed(m_tdata_i[63:32]),
                   $signed(m_tdata_i[95:64]), $signed(m_tdata_i[127:96]),
                   m_tdata_i[158:128], m_tdata_i[189:159], m_tlast_i};
          foreach (want[i]) begin
            if (want[i] != seen[i]) begin
              $error("%s: expected %0d, got %0d", field_name[i], want[i], seen[i]);
              mismatches++;
            end
          end
        end
      end
      pending_o <= predicted_moves.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;
  import pbb_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_index_i = REG_TIME_STEP;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // fields from bit 0: pos_x, pos_y, vel_x, vel_y, speed, one pad bit
  logic [159:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // fields from bit 0: new_pos_x, new_pos_y, new_vel_x, new_vel_y, speed_out,
  // mean_speed, two pad bits
  logic [191:0] m_axis_tdata;
  logic         m_axis_tlast;

  int pending;
  int failures;
  bit calm = 1'b0;
  int frame_left = 0;

  particle_box_bounce_step_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  pbb_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .pending_o   (pending),
    .failures_o  (failures)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 37);
  end

  initial begin
    #(2_000_000 * 12);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_particle(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic signed [31:0] vx, input logic signed [31:0] vy,
                               input logic [30:0] spd, input logic last);
    while (!calm && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, spd, vy, vx, y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Mostly particles near the box with modest velocities, some fully random.
  task automatic send_random();
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        spd;
    if (frame_left == 0) frame_left = $urandom_range(1, 20);
    frame_left--;
    if ($urandom_range(0, 9) == 0) begin
      x   = $urandom;
      y   = $urandom;
      vx  = $urandom;
      vy  = $urandom;
      spd = 31'($urandom);
    end else begin
      x   = $urandom_range(300 * 65536, 1100 * 65536);
      y   = $urandom_range(0, 800 * 65536) - 50 * 65536;
      vx  = $urandom_range(0, 1 << 20) - (1 << 19);
      vy  = $urandom_range(0, 1 << 20) - (1 << 19);
      spd = 31'($urandom_range(0, 1 << 22));
    end
    send_particle(x, y, vx, vy, spd, frame_left == 0);
  endtask

  // Every particle yields a result, so an empty queue means the block is idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] ts, input logic [31:0] grav,
                           input logic [31:0] rad);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_TIME_STEP;
    cfg_data_i  <= ts;
    @(posedge clk_i);
    cfg_index_i <= REG_GRAVITY;
    cfg_data_i  <= grav;
    @(posedge clk_i);
    cfg_index_i <= REG_RADIUS;
    cfg_data_i  <= rad;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: each wall from far outside, negation of the most negative
    // velocity, and a one-particle frame at full speed.
    send_particle(0, 0, 0, 0, 31'd0, 1'b0);
    send_particle(32'sh7fff_ffff, 350 * 65536, 32'sh8000_0000, 65536, 31'h7fff_ffff, 1'b0);
    send_particle(32'sh8000_0000, 350 * 65536, 32'sh7fff_ffff, -65536, 31'd1, 1'b0);
    send_particle(700 * 65536, 32'sh7fff_ffff, -65536, 32'sh8000_0000, 31'd12345, 1'b0);
    send_particle(700 * 65536, 32'sh8000_0000, 65536, 32'sh7fff_ffff, 31'd0, 1'b0);
    send_particle(700 * 65536, 350 * 65536, 65536, -65536, 31'h7fff_ffff, 1'b1);
    send_particle(500 * 65536, 100 * 65536, -3000, 4000, 31'h7fff_ffff, 1'b1);
    drain();

    // Radius so large that opposite walls overlap; extreme step and gravity.
    configure(32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_particle(0, 0, 1, 1, 31'd100, 1'b0);
    send_particle(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                  31'd200, 1'b0);
    send_particle(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  31'd300, 1'b0);
    send_particle(700 * 65536, 350 * 65536, -7, 9, 31'd400, 1'b1);
    drain();

    // Zero radius and zero step: positions exactly on and just past each wall.
    configure(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
    send_particle(1050 * 65536, 0, 65536, 65536, 31'd5, 1'b0);
    send_particle(1050 * 65536 + 1, 700 * 65536, 65536, 65536, 31'd6, 1'b0);
    send_particle(350 * 65536, 700 * 65536 + 1, -65536, -65536, 31'd7, 1'b0);
    send_particle(350 * 65536 - 1, -1, -65536, -65536, 31'd8, 1'b0);
    send_particle(600 * 65536, 300 * 65536, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'd9, 1'b0);
    send_particle(600 * 65536, 300 * 65536, 32'sh8000_0000, 32'sh8000_0000, 31'd10, 1'b0);
    send_particle(600 * 65536, 300 * 65536, 0, 0, 31'd11, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure(32'd65536, -32'sd642, 32'd131072);
        1: configure($urandom_range(0, 4 * 65536), $urandom_range(0, 65536) - 32768,
                     $urandom_range(0, 40 * 65536));
        2: configure(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000);
        3: configure(32'h0000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        4: configure($urandom, $urandom, $urandom);
        default: configure(32'd65536, 32'h8000_0000, $urandom_range(0, 400 * 65536));
      endcase
      calm = (p == 1);
      repeat (250) send_random();
      calm = 1'b0;
      drain();
    end

    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pbb_pkg.sv
rtl/pbb_front.sv
rtl/pbb_queue.sv
rtl/pbb_back.sv
rtl/particle_box_bounce_step_top.sv
bench/pbb_checker.sv
bench/tb_top.sv
